FILE: hw/rtl/capture_record_deframer_unit_macros.svh
// ----------------------------------------------------------------------------
// capture record deframer assertion macros
// concurrent assertion shorthands on clk with rst as disable
// ----------------------------------------------------------------------------
`ifndef CAPTURE_RECORD_DEFRAMER_UNIT_MACROS_SVH
`define CAPTURE_RECORD_DEFRAMER_UNIT_MACROS_SVH

// same-cycle implication
`define CRD_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CRD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/crd_pkg.sv
// ----------------------------------------------------------------------------
// crd_pkg
// shared types and constants of the capture record deframer
// ----------------------------------------------------------------------------
`default_nettype none

package crd_pkg;

  localparam int MAX_READ_BYTES      = 65536;
  localparam int RECORD_HEADER_BYTES = 16;
  localparam int HDR_FIELD_BYTES     = 18;
  localparam int MIN_REMAINDER       = 20;
  localparam int HDR_IDX_W           = $clog2(HDR_FIELD_BYTES);
  localparam int LEN_W               = 17;
  localparam int CFG_IDX_W           = 2;
  localparam int CFG_DATA_W          = 32;
  localparam int OUT_DEPTH           = 2;
  localparam int OUT_PTR_W           = $clog2(OUT_DEPTH);
  localparam int OUT_CNT_W           = $clog2(OUT_DEPTH + 1);

  localparam logic [31:0] FILE_START_RESET = 32'd24;

  localparam logic [1:0] KIND_DESCRIPTOR = 2'd0;
  localparam logic [1:0] KIND_PAYLOAD    = 2'd1;
  localparam logic [1:0] KIND_LIMIT      = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_RECORD_LIMIT    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FILE_SIZE_LIMIT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FILE_START      = 2'd2;

  typedef struct packed {
    logic [7:0]       data_byte;
    logic [LEN_W-1:0] read_length;
  } crd_item_t;

  typedef struct packed {
    logic [1:0]       kind;
    logic [31:0]      seconds;
    logic [31:0]      microseconds;
    logic [LEN_W-1:0] captured_length;
    logic [31:0]      wire_length;
    logic [7:0]       payload_byte;
    logic             last_of_record;
  } crd_result_t;

  typedef struct packed {
    logic             limit_reached;
    logic             header_done;
    logic [LEN_W-1:0] payload_left;
  } crd_status_t;

endpackage

`default_nettype wire

FILE: hw/rtl/crd_in_stage.sv
// ----------------------------------------------------------------------------
// crd_in_stage
// input register: holds one request until the parser takes it
// ----------------------------------------------------------------------------
`default_nettype none

module crd_in_stage import crd_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             item_valid,
  input  wire logic [7:0]       data_byte,
  input  wire logic [LEN_W-1:0] read_length,
  output logic                  item_stall,
  input  wire logic             advance,
  output logic                  q_valid,
  output crd_item_t             q_item
);

  logic accept;

  assign item_stall = q_valid && !advance;
  assign accept     = item_valid && !item_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (accept) begin
      q_valid <= 1'b1;
    end else if (advance) begin
      q_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      q_item.data_byte   <= data_byte;
      q_item.read_length <= read_length;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/crd_parser.sv
// ----------------------------------------------------------------------------
// crd_parser
// record walker: position tracking, header capture, limit checks, results
// ----------------------------------------------------------------------------
`default_nettype none

module crd_parser import crd_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  step,
  input  wire crd_item_t             item,
  input  wire logic                  cfg_write,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  output logic                       res_valid,
  output crd_result_t                res,
  output crd_status_t                status
);

  logic [31:0]      record_limit;
  logic [31:0]      file_size_limit;
  logic [LEN_W-1:0] read_position;
  logic [LEN_W-1:0] record_start;
  logic [LEN_W:0]   record_end;
  logic [7:0]       hdr [HDR_FIELD_BYTES];
  logic [15:0]      header_length;
  logic [LEN_W-1:0] payload_left;
  logic [31:0]      record_count;
  logic [31:0]      file_length;
  logic             skip_rest_of_read;
  logic             limit_reached;
  logic             header_done;

  logic [LEN_W-1:0] read_position_next;
  logic [LEN_W-1:0] record_start_next;
  logic [LEN_W:0]   record_end_next;
  logic [15:0]      header_length_next;
  logic [LEN_W-1:0] payload_left_next;
  logic [31:0]      record_count_next;
  logic [31:0]      file_length_next;
  logic             skip_rest_of_read_next;
  logic             limit_reached_next;
  logic             header_done_next;
  logic             hdr_we;

  logic [LEN_W-1:0] eff;
  logic [LEN_W-1:0] pos;
  logic [LEN_W:0]   pos_inc;
  logic             pos_zero;
  logic [LEN_W-1:0] rs_a;
  logic             hd_a;
  logic             sk_a;
  logic             adv_rec;
  logic [LEN_W-1:0] rs_b;
  logic             hd_b;
  logic [LEN_W-1:0] off;
  logic [LEN_W-1:0] remain;
  logic             short_rest;
  logic [15:0]      hl;
  logic [31:0]      cl;
  logic [LEN_W+1:0] rec_span_end;
  logic             bad_header;
  logic [33:0]      file_need;
  logic             limit_trip;
  logic [LEN_W:0]   span;

  always_comb begin
    eff = item.read_length;
    if (eff == '0) begin
      eff = LEN_W'(1);
    end else if (eff > LEN_W'(MAX_READ_BYTES)) begin
      eff = LEN_W'(MAX_READ_BYTES);
    end
  end

  assign pos      = (read_position >= eff) ? '0 : read_position;
  assign pos_inc  = {1'b0, pos} + (LEN_W+1)'(1);
  assign pos_zero = (pos == '0);

  assign rs_a    = pos_zero ? '0 : record_start;
  assign hd_a    = !pos_zero && header_done;
  assign sk_a    = !pos_zero && skip_rest_of_read;
  assign adv_rec = hd_a && ({1'b0, pos} >= record_end);
  assign rs_b    = adv_rec ? record_end[LEN_W-1:0] : rs_a;
  assign hd_b    = hd_a && !adv_rec;
  assign off     = pos - rs_b;
  assign remain  = eff - pos;

  assign short_rest = !hd_b && (pos == rs_b) && (remain < LEN_W'(MIN_REMAINDER));

  assign hl = {hdr[16], item.data_byte};
  assign cl = {hdr[8], hdr[9], hdr[10], hdr[11]};

  assign rec_span_end = {2'b0, rs_b} + {3'b0, hl} + {2'b0, cl[LEN_W-1:0]};
  assign bad_header   = (hl < 16'(HDR_FIELD_BYTES)) || (|cl[31:LEN_W])
                        || (rec_span_end > {2'b0, eff});

  assign file_need = {2'b0, file_length} + 34'(RECORD_HEADER_BYTES) + {2'b0, cl};
  assign limit_trip = ((record_limit != '0) && (record_count >= record_limit))
                      || ((file_size_limit != '0) && (file_need > {2'b0, file_size_limit}));

  assign span = ({2'b0, hl} + {1'b0, cl[LEN_W-1:0]} + (LEN_W+1)'(3))
                & ~(LEN_W+1)'(3);

  always_comb begin
    read_position_next     = (pos_inc >= {1'b0, eff}) ? '0 : pos_inc[LEN_W-1:0];
    record_start_next      = record_start;
    record_end_next        = record_end;
    header_length_next     = header_length;
    payload_left_next      = payload_left;
    record_count_next      = record_count;
    file_length_next       = file_length;
    skip_rest_of_read_next = skip_rest_of_read;
    limit_reached_next     = limit_reached;
    header_done_next       = header_done;
    hdr_we                 = 1'b0;
    res_valid              = 1'b0;
    res                    = '0;

    if (!limit_reached) begin
      record_start_next      = rs_a;
      header_done_next       = hd_a;
      skip_rest_of_read_next = sk_a;
      if (!sk_a) begin
        record_start_next = rs_b;
        header_done_next  = hd_b;
        if (!hd_b) begin
          if (short_rest) begin
            skip_rest_of_read_next = 1'b1;
          end else if (off < LEN_W'(HDR_FIELD_BYTES)) begin
            hdr_we = 1'b1;
            if (off == LEN_W'(HDR_FIELD_BYTES - 1)) begin
              if (bad_header) begin
                skip_rest_of_read_next = 1'b1;
              end else if (limit_trip) begin
                limit_reached_next = 1'b1;
                res_valid          = 1'b1;
                res.kind           = KIND_LIMIT;
              end else begin
                header_length_next  = hl;
                payload_left_next   = cl[LEN_W-1:0];
                header_done_next    = 1'b1;
                record_end_next     = {1'b0, rs_b} + span;
                record_count_next   = record_count + 32'd1;
                file_length_next    = file_length + 32'(RECORD_HEADER_BYTES) + cl;
                res_valid           = 1'b1;
                res.kind            = KIND_DESCRIPTOR;
                res.seconds         = {hdr[0], hdr[1], hdr[2], hdr[3]};
                res.microseconds    = {hdr[4], hdr[5], hdr[6], hdr[7]};
                res.captured_length = cl[LEN_W-1:0];
                res.wire_length     = {hdr[12], hdr[13], hdr[14], hdr[15]};
                res.last_of_record  = (cl == '0);
              end
            end
          end
        end else if ((off >= {1'b0, header_length}) && (payload_left != '0)) begin
          payload_left_next  = payload_left - LEN_W'(1);
          res_valid          = 1'b1;
          res.kind           = KIND_PAYLOAD;
          res.payload_byte   = item.data_byte;
          res.last_of_record = (payload_left == LEN_W'(1));
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      record_limit      <= '0;
      file_size_limit   <= '0;
      read_position     <= '0;
      record_start      <= '0;
      record_end        <= '0;
      header_length     <= '0;
      payload_left      <= '0;
      record_count      <= '0;
      file_length       <= FILE_START_RESET;
      skip_rest_of_read <= 1'b0;
      limit_reached     <= 1'b0;
      header_done       <= 1'b0;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_RECORD_LIMIT:    record_limit    <= cfg_data;
        CFG_FILE_SIZE_LIMIT: file_size_limit <= cfg_data;
        CFG_FILE_START:      file_length     <= {16'b0, cfg_data[15:0]};
        default: ;
      endcase
    end else if (step) begin
      read_position     <= read_position_next;
      record_start      <= record_start_next;
      record_end        <= record_end_next;
      header_length     <= header_length_next;
      payload_left      <= payload_left_next;
      record_count      <= record_count_next;
      file_length       <= file_length_next;
      skip_rest_of_read <= skip_rest_of_read_next;
      limit_reached     <= limit_reached_next;
      header_done       <= header_done_next;
    end
  end

  always_ff @(posedge clk) begin
    if (step && hdr_we) begin
      hdr[off[HDR_IDX_W-1:0]] <= item.data_byte;
    end
  end

  assign status.limit_reached = limit_reached;
  assign status.header_done   = header_done;
  assign status.payload_left  = payload_left;

endmodule

`default_nettype wire

FILE: hw/rtl/crd_out_fifo.sv
// ----------------------------------------------------------------------------
// crd_out_fifo
// two-entry result buffer between the parser and the result channel
// ----------------------------------------------------------------------------
`default_nettype none

module crd_out_fifo import crd_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  input  wire crd_result_t push_data,
  input  wire logic        pop,
  output logic             head_valid,
  output crd_result_t      head_data,
  output logic             full
);

  crd_result_t          mem [OUT_DEPTH];
  logic [OUT_PTR_W-1:0] wr_ptr;
  logic [OUT_PTR_W-1:0] rd_ptr;
  logic [OUT_CNT_W-1:0] count;

  assign head_valid = (count != '0);
  assign full       = (count == OUT_CNT_W'(OUT_DEPTH));
  assign head_data  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + OUT_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + OUT_PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + OUT_CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - OUT_CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/capture_record_deframer_unit.sv
// ----------------------------------------------------------------------------
// capture_record_deframer_unit
// splits capture-buffer reads into record descriptors and payload bytes
// ----------------------------------------------------------------------------
// item channel: one buffer byte per request with the length of its read,
//   taken when item_valid is high and item_stall is low
// result channel: descriptor, payload byte or limit notice, taken when
//   result_valid is high and result_stall is low
// cfg port: cfg_write with cfg_index selects record limit, file size limit or
//   file start bytes; the user writes only while the block is idle (unchecked)
// path: a byte that makes a result goes into the input register, then the
//   parser writes its result into the result buffer once that is not full
// throughput: one byte per cycle while the result buffer is not full
// header bytes before the last, padding and skipped reads give no result
// reset: clears position, counters, limits and the buffers; file length
//   returns to 24
// stall: a two-entry result buffer keeps taking bytes until it is full, then
//   item_stall rises; no result is dropped
// ----------------------------------------------------------------------------
`default_nettype none

module capture_record_deframer_unit import crd_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  item_valid,
  output logic                       item_stall,
  input  wire logic [7:0]            data_byte,
  input  wire logic [LEN_W-1:0]      read_length,
  output logic                       result_valid,
  input  wire logic                  result_stall,
  output logic [1:0]                 kind,
  output logic [31:0]                seconds,
  output logic [31:0]                microseconds,
  output logic [LEN_W-1:0]           captured_length,
  output logic [31:0]                wire_length,
  output logic [7:0]                 payload_byte,
  output logic                       last_of_record,
  input  wire logic                  cfg_write,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  `include "capture_record_deframer_unit_macros.svh"

  logic        q_valid;
  crd_item_t   q_item;
  logic        advance;
  logic        res_valid;
  crd_result_t res;
  crd_status_t status;
  logic        push;
  logic        pop;
  logic        full;
  crd_result_t head;

  assign advance = q_valid && !full;
  assign push    = advance && res_valid;
  assign pop     = result_valid && !result_stall;

  crd_in_stage u_in_stage (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .data_byte   (data_byte),
    .read_length (read_length),
    .item_stall  (item_stall),
    .advance     (advance),
    .q_valid     (q_valid),
    .q_item      (q_item)
  );

  crd_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .step      (advance),
    .item      (q_item),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .res_valid (res_valid),
    .res       (res),
    .status    (status)
  );

  crd_out_fifo u_out_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_data  (res),
    .pop        (pop),
    .head_valid (result_valid),
    .head_data  (head),
    .full       (full)
  );

  assign kind            = head.kind;
  assign seconds         = head.seconds;
  assign microseconds    = head.microseconds;
  assign captured_length = head.captured_length;
  assign wire_length     = head.wire_length;
  assign payload_byte    = head.payload_byte;
  assign last_of_record  = head.last_of_record;

  `CRD_ASSERT_NEXT(a_limit_sticky, status.limit_reached && !cfg_write,
    status.limit_reached, "limit flag dropped without reset")
  `CRD_ASSERT_IMP(a_quiet_after_limit, advance && status.limit_reached, !res_valid,
    "result produced after limit reached")
  `CRD_ASSERT_NEXT(a_last_empties_payload,
    push && (res.kind == KIND_PAYLOAD) && res.last_of_record,
    status.payload_left == '0, "payload count not empty after last byte")

endmodule

`default_nettype wire
